// File: rtl/gmt_pkg.sv
// Shared types and constants for the geared multi-turn encoder tracker.
`timescale 1ns / 1ps

package gmt_pkg;

    // Field widths
    localparam int POS_W   = 16;
    localparam int SPD_W   = 16;
    localparam int ACC_W   = 17;
    localparam int CNT_W   = 32;
    localparam int TURN_W  = 24;
    localparam int ANG_W   = 32;
    localparam int TOT_W   = 48;
    localparam int MINOR_W = 16;
    localparam int RATIO_W = 8;

    // Encoder geometry and scaling
    localparam int ENC_SHIFT   = 13;          // 8192 counts per rotor turn
    localparam int ENC_COUNTS  = 8192;
    localparam int TOP_BAND    = 7000;
    localparam int BOTTOM_BAND = 2000;
    localparam int ANGLE_SCALE = 2880;        // 360 * 65536 / 8192
    localparam int TURN_Q16    = 23592960;    // 360 degrees in Q16.16

    // Divider: |within * 2880| fits in 44 bits
    localparam int PROD_W    = 44;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    // Register bus
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_GEAR_RATIO = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_UNWRAP,
        ST_MULT,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic step;
        logic unwrap;
        logic mult;
        logic load;
        logic div_step;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: rtl/gmt_if.sv
// Valid/ready channel interfaces for frames in and results out.
`timescale 1ns / 1ps

interface gmt_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] raw_position;
    logic signed [15:0] speed_sample;

    modport source(output valid, raw_position, speed_sample, input ready);
    modport sink(input valid, raw_position, speed_sample, output ready);
endinterface

interface gmt_out_if;
    logic               valid;
    logic               ready;
    logic               fault;
    logic signed [16:0] accel;
    logic signed [31:0] shaft_count;
    logic signed [23:0] shaft_turns;
    logic signed [31:0] angle_deg;
    logic signed [47:0] total_angle_deg;

    modport source(output valid, fault, accel, shaft_count, shaft_turns, angle_deg,
                   total_angle_deg, input ready);
    modport sink(input valid, fault, accel, shaft_count, shaft_turns, angle_deg,
                 total_angle_deg, output ready);
endinterface

// File: rtl/gmt_ctrl.sv
// Sequencer for one frame: wrap step, unwrap, multiply, divide, finish.
`timescale 1ns / 1ps

module gmt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gmt_pkg::t_status i_status,
    output gmt_pkg::t_cmd    o_cmd
);
    import gmt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_STEP;
            end
            ST_STEP:   n_state = ST_UNWRAP;
            ST_UNWRAP: n_state = ST_MULT;
            ST_MULT:   n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register can take the word
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_STEP:   o_cmd.step     = 1'b1;
            ST_UNWRAP: o_cmd.unwrap   = 1'b1;
            ST_MULT:   o_cmd.mult     = 1'b1;
            ST_LOAD:   o_cmd.load     = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_FIN:    o_cmd.finish   = 1'b1;
            default:   o_cmd          = '0;
        endcase
    end

endmodule

// File: rtl/gmt_datapath.sv
// Tracking state, angle multiply, bit-serial divider and output register.
`timescale 1ns / 1ps

module gmt_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gmt_pkg::t_cmd        i_cmd,
    output gmt_pkg::t_status     o_status,
    input  logic [7:0]           i_ratio,
    input  logic signed [15:0]   i_raw_position,
    input  logic signed [15:0]   i_speed_sample,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_fault,
    output logic signed [16:0]   o_accel,
    output logic signed [31:0]   o_shaft_count,
    output logic signed [23:0]   o_shaft_turns,
    output logic signed [31:0]   o_angle_deg,
    output logic signed [47:0]   o_total_angle_deg
);
    import gmt_pkg::*;

    localparam logic signed [POS_W-1:0]  TOP_S    = POS_W'(TOP_BAND);
    localparam logic signed [POS_W-1:0]  BOT_S    = POS_W'(BOTTOM_BAND);
    localparam logic signed [POS_W-1:0]  ENC_S    = POS_W'(ENC_COUNTS);
    localparam logic signed [CNT_W-1:0]  ENC_C    = CNT_W'(ENC_COUNTS);
    localparam logic signed [PROD_W-1:0] SCALE_S  = PROD_W'(ANGLE_SCALE);
    localparam logic signed [TOT_W:0]    TURN_S   = (TOT_W + 1)'(TURN_Q16);
    localparam int                       LOW_W    = CNT_W - ENC_SHIFT;

    // Frame capture
    logic signed [POS_W-1:0]   r_pos;
    logic signed [SPD_W-1:0]   r_spd;

    // Tracking state
    logic signed [SPD_W-1:0]   r_last_speed;
    logic                      r_near_top, r_crossed_top, r_near_bot, r_crossed_bot;
    logic signed [MINOR_W-1:0] r_minor;
    logic signed [CNT_W-1:0]   r_rec;
    logic signed [CNT_W-1:0]   r_within;
    logic signed [TURN_W-1:0]  r_major;
    logic signed [ANG_W-1:0]   r_held_angle;
    logic signed [TOT_W-1:0]   r_held_total;

    // Per-frame working registers
    logic                      r_fault;
    logic signed [ACC_W-1:0]   r_accel;
    logic                      r_upd;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [TOT_W-1:0]   r_turn_prod;
    logic [PROD_W-1:0]         r_quo;
    logic [RATIO_W-1:0]        r_rem;
    logic                      r_neg;
    logic [DIV_CNT_W-1:0]      r_cnt;

    // Output register
    logic                      r_out_valid;
    logic                      r_out_fault;
    logic signed [ACC_W-1:0]   r_out_accel;
    logic signed [CNT_W-1:0]   r_out_count;
    logic signed [TURN_W-1:0]  r_out_turns;
    logic signed [ANG_W-1:0]   r_out_angle;
    logic signed [TOT_W-1:0]   r_out_total;

    // Wrap step: band flags, crossing flags, minor turn and record updates, fault and accel
    logic                      n_near_top, n_crossed_top, n_near_bot, n_crossed_bot;
    logic signed [MINOR_W-1:0] n_minor;
    logic signed [CNT_W-1:0]   n_rec;
    logic                      n_fault;
    logic signed [ACC_W-1:0]   n_accel;

    always_comb begin
        n_near_top    = r_near_top;
        n_crossed_top = r_crossed_top;
        n_near_bot    = r_near_bot;
        n_crossed_bot = r_crossed_bot;
        if (r_pos < TOP_S && r_pos > BOT_S) begin
            n_near_top    = 1'b0;
            n_crossed_top = 1'b0;
            n_near_bot    = 1'b0;
            n_crossed_bot = 1'b0;
        end else if (r_pos > TOP_S) begin
            n_near_top = 1'b1;
        end else if (r_pos < BOT_S) begin
            n_near_bot = 1'b1;
        end
        if (n_near_top && r_pos < BOT_S) begin
            n_crossed_top = 1'b1;
        end else if (n_near_bot && r_pos > TOP_S) begin
            n_crossed_bot = 1'b1;
        end
        n_minor = r_minor;
        n_rec   = r_rec;
        if (n_near_top && n_crossed_top) begin
            n_minor       = r_minor + MINOR_W'(1);
            n_rec         = r_rec + ENC_C;
            n_near_top    = 1'b0;
            n_crossed_top = 1'b0;
        end else if (n_near_bot && n_crossed_bot) begin
            n_minor       = r_minor - MINOR_W'(1);
            n_rec         = r_rec - ENC_C;
            n_near_bot    = 1'b0;
            n_crossed_bot = 1'b0;
        end
        n_fault = (r_pos <= 0) || (r_pos > ENC_S);
        n_accel = {r_spd[SPD_W-1], r_spd} - {r_last_speed[SPD_W-1], r_last_speed};
    end

    // Unwrap: count within shaft turn, shaft turn rollover
    logic signed [CNT_W-1:0]   pos_x, minor_x, ratio_x, turns_x, low_x, limit_x;
    logic signed [CNT_W-1:0]   n_within, n_unw_rec;
    logic signed [TURN_W-1:0]  n_major;
    logic signed [MINOR_W-1:0] n_unw_minor;
    logic                      roll_up, roll_dn;

    always_comb begin
        pos_x   = {{(CNT_W - POS_W){r_pos[POS_W-1]}}, r_pos};
        minor_x = {{(CNT_W - MINOR_W){r_minor[MINOR_W-1]}}, r_minor};
        ratio_x = {{(CNT_W - RATIO_W){1'b0}}, i_ratio};
        turns_x = ratio_x + minor_x - CNT_W'(1);
        low_x   = ratio_x - CNT_W'(1);
        limit_x = {ratio_x[LOW_W-1:0], {ENC_SHIFT{1'b0}}};
        if (!r_minor[MINOR_W-1] && r_minor != '0) begin
            n_within = {minor_x[LOW_W-1:0], {ENC_SHIFT{1'b0}}} + pos_x;
        end else if (r_minor[MINOR_W-1] || r_rec > ENC_C) begin
            n_within = {turns_x[LOW_W-1:0], {ENC_SHIFT{1'b0}}} + pos_x;
        end else begin
            n_within = pos_x;
        end
        roll_up     = r_rec > limit_x;
        roll_dn     = r_rec[CNT_W-1];
        n_unw_rec   = r_rec;
        n_major     = r_major;
        n_unw_minor = r_minor;
        if (roll_up) begin
            n_unw_rec   = pos_x;
            n_major     = r_major + TURN_W'(1);
            n_unw_minor = '0;
        end else if (roll_dn) begin
            n_unw_rec   = {low_x[LOW_W-1:0], {ENC_SHIFT{1'b0}}} + pos_x;
            n_major     = r_major - TURN_W'(1);
            n_unw_minor = '0;
        end
    end

    // Multipliers: within * 2880 and shaft turns * 360 degrees
    logic signed [PROD_W-1:0] within_x;
    logic signed [TOT_W:0]    major_x;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [TOT_W:0]    turn_full;

    always_comb begin
        within_x  = {{(PROD_W - CNT_W){r_within[CNT_W-1]}}, r_within};
        major_x   = {{(TOT_W + 1 - TURN_W){r_major[TURN_W-1]}}, r_major};
        n_prod    = within_x * SCALE_S;
        turn_full = major_x * TURN_S;
    end

    // Restoring divider step, one quotient bit per cycle
    logic [RATIO_W:0]   trial;
    logic [RATIO_W:0]   trial_diff;
    logic               q_bit;

    always_comb begin
        trial      = {r_rem, r_quo[PROD_W-1]};
        trial_diff = trial - {1'b0, i_ratio};
        q_bit      = (trial >= {1'b0, i_ratio});
    end

    // Finish: signed quotient, total angle, held values
    logic [PROD_W-1:0]       sq;
    logic signed [ANG_W-1:0] ang;
    logic signed [TOT_W-1:0] tot;
    logic signed [ANG_W-1:0] n_held_angle;
    logic signed [TOT_W-1:0] n_held_total;

    always_comb begin
        sq           = r_neg ? (~r_quo + PROD_W'(1)) : r_quo;
        ang          = sq[ANG_W-1:0];
        tot          = r_turn_prod + {{(TOT_W - ANG_W){ang[ANG_W-1]}}, ang};
        n_held_angle = r_upd ? ang : r_held_angle;
        n_held_total = r_upd ? tot : r_held_total;
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.div_done = i_cmd.div_step && (r_cnt == DIV_CNT_W'(PROD_W - 1));

    // Tracking state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_speed  <= '0;
            r_near_top    <= 1'b0;
            r_crossed_top <= 1'b0;
            r_near_bot    <= 1'b0;
            r_crossed_bot <= 1'b0;
            r_minor       <= '0;
            r_rec         <= '0;
            r_within      <= '0;
            r_major       <= '0;
            r_held_angle  <= '0;
            r_held_total  <= '0;
        end else begin
            if (i_cmd.step) begin
                r_last_speed  <= r_spd;
                r_near_top    <= n_near_top;
                r_crossed_top <= n_crossed_top;
                r_near_bot    <= n_near_bot;
                r_crossed_bot <= n_crossed_bot;
                r_minor       <= n_minor;
                r_rec         <= n_rec;
            end else if (i_cmd.unwrap) begin
                r_within <= n_within;
                r_rec    <= n_unw_rec;
                r_major  <= n_major;
                r_minor  <= n_unw_minor;
            end
            if (i_cmd.finish) begin
                r_held_angle <= n_held_angle;
                r_held_total <= n_held_total;
            end
        end
    end

    // Per-frame working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos <= i_raw_position;
            r_spd <= i_speed_sample;
        end
        if (i_cmd.step) begin
            r_fault <= n_fault;
            r_accel <= n_accel;
        end
        if (i_cmd.unwrap) begin
            r_upd <= !roll_up && !roll_dn;
        end
        if (i_cmd.mult) begin
            r_prod      <= n_prod;
            r_turn_prod <= turn_full[TOT_W-1:0];
        end
        if (i_cmd.load) begin
            r_neg <= r_prod[PROD_W-1];
            r_quo <= r_prod[PROD_W-1] ? (~r_prod + PROD_W'(1)) : r_prod;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[PROD_W-2:0], q_bit};
            r_rem <= q_bit ? trial_diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
        end
    end

    // Divider step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    // Output register: loads at finish once the previous word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish && o_status.out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && o_status.out_free) begin
            r_out_fault <= r_fault;
            r_out_accel <= r_accel;
            r_out_count <= r_within;
            r_out_turns <= r_major;
            r_out_angle <= n_held_angle;
            r_out_total <= n_held_total;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_fault           = r_out_fault;
    assign o_accel           = r_out_accel;
    assign o_shaft_count     = r_out_count;
    assign o_shaft_turns     = r_out_turns;
    assign o_angle_deg       = r_out_angle;
    assign o_total_angle_deg = r_out_total;

endmodule

// File: rtl/geared_multiturn_encoder_tracker.sv
// Top level: register bus, controller and datapath of the encoder tracker.
`timescale 1ns / 1ps

// Geared multi-turn encoder tracker.
// i_in carries one motor feedback frame per word (raw_position, speed_sample);
// o_out carries one result word per frame: fault, accel, shaft_count,
// shaft_turns, angle_deg (Q16.16) and total_angle_deg (Q32.16).
// Both are valid/ready channels; a word moves when valid and ready are high.
// gear_ratio is written over the APB-style port at byte address 0 (reset 1,
// a value of 0 acts as 1); write it only while no frame is in flight.
// A new frame is accepted only once the previous one has left the finish step;
// the 44-step restoring divider forms within * 2880 / ratio one quotient bit
// per cycle.
// The output register parts the two channels: a new frame is accepted while
// the previous result still waits; if the receiver stalls, the next result
// holds in the finish step until the output register frees up.
// Reset (synchronous, active low) clears all tracking state, empties the
// output register and restores gear_ratio to 1.
module geared_multiturn_encoder_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gmt_in_if.sink                            i_in,
    gmt_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gmt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [gmt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [gmt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import gmt_pkg::*;

    logic [RATIO_W-1:0] r_gear_ratio;
    logic [RATIO_W-1:0] ratio_eff;
    logic [0:0]         reg_idx;
    logic               cfg_wr;
    logic               w_in_ready;
    t_cmd               w_cmd;
    t_status            w_status;

    // Register bus
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear_ratio <= RATIO_W'(1);
        end else if (cfg_wr && reg_idx == REG_GEAR_RATIO) begin
            r_gear_ratio <= pwdata[RATIO_W-1:0];
        end
    end

    assign prdata    = (reg_idx == REG_GEAR_RATIO)
                     ? {{(APB_DATA_W - RATIO_W){1'b0}}, r_gear_ratio} : '0;
    assign ratio_eff = (r_gear_ratio == '0) ? RATIO_W'(1) : r_gear_ratio;

    assign i_in.ready = w_in_ready;

    gmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gmt_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_ratio           (ratio_eff),
        .i_raw_position    (i_in.raw_position),
        .i_speed_sample    (i_in.speed_sample),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_fault           (o_out.fault),
        .o_accel           (o_out.accel),
        .o_shaft_count     (o_out.shaft_count),
        .o_shaft_turns     (o_out.shaft_turns),
        .o_angle_deg       (o_out.angle_deg),
        .o_total_angle_deg (o_out.total_angle_deg)
    );

    // One frame at a time: no accept right after an accept
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("frame accepted while previous frame in flight");

    // A result appears only out of the finish step
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.finish))
        else $error("result word loaded outside finish step");

    // Divider completion is followed by the finish step
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.div_done |=> w_cmd.finish)
        else $error("divider done without moving to finish");

endmodule

// File: sim/geared_multiturn_encoder_tracker_tb.sv
// Self-checking testbench for the geared multi-turn encoder tracker.
`timescale 1ns / 1ps

module geared_multiturn_encoder_tracker_tb;
    import gmt_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 60;     // a little over the result latency
    localparam int FRAMES_PER_SET  = 80;
    localparam int CALM_FRAMES     = 15;     // stretch without idling at each set start
    localparam int LONG_HOLD       = 400;
    localparam int REPORT_LIMIT    = 10;
    localparam int ENC_PERIOD      = 8192;
    localparam logic [APB_ADDR_W-1:0] GEAR_RATIO_ADDR = APB_ADDR_W'(4 * REG_GEAR_RATIO);

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One result word as seen on the output channel
    typedef struct packed {
        logic                fault;
        logic signed [16:0]  accel;
        logic signed [31:0]  shaft_count;
        logic signed [23:0]  shaft_turns;
        logic signed [31:0]  angle_deg;
        logic signed [47:0]  total_angle_deg;
    } shaft_report_t;

    // Directed frame with an optional hand-typed result
    typedef struct packed {
        logic signed [15:0]  pos;
        logic signed [15:0]  spd;
        logic                typed;
        shaft_report_t       want;
    } frame_row_t;

    localparam shaft_report_t NO_REPORT = '0;
    localparam int DIR_ROWS = 17;
    localparam frame_row_t FRAME_TABLE [DIR_ROWS] = '{
        // after reset: low band, ratio 1
        '{16'sd100,    16'sd0,      1'b1, '{1'b0, 17'sd0, 32'sd100, 24'sd0,
                                            32'sd288000, 48'sd288000}},
        // zero position is a fault, speed at its top
        '{16'sd0,      16'sd32767,  1'b1, '{1'b1, 17'sd32767, 32'sd0, 24'sd0,
                                            32'sd0, 48'sd0}},
        // top valid count, speed swing to the bottom: backward wrap, turn down
        '{16'sd8192,   -16'sd32768, 1'b0, NO_REPORT},
        '{16'sd4000,   16'sd32767,  1'b0, NO_REPORT},
        // band edges leave the near flags alone
        '{16'sd7000,   16'sd0,      1'b0, NO_REPORT},
        '{16'sd2000,   16'sd0,      1'b0, NO_REPORT},
        // forward wrap
        '{16'sd7500,   16'sd5,      1'b0, NO_REPORT},
        '{16'sd500,    16'sd5,      1'b0, NO_REPORT},
        '{16'sd1,      16'sd0,      1'b0, NO_REPORT},
        // faulty positions still feed the tracking
        '{-16'sd32768, 16'sd0,      1'b0, NO_REPORT},
        '{16'sd32767,  16'sd0,      1'b0, NO_REPORT},
        '{-16'sd1,     -16'sd1,     1'b0, NO_REPORT},
        '{16'sd8193,   16'sd1,      1'b0, NO_REPORT},
        '{16'sd6000,   16'sd0,      1'b0, NO_REPORT},
        '{16'sd1500,   -16'sd200,   1'b0, NO_REPORT},
        '{16'sd7999,   16'sd300,    1'b0, NO_REPORT},
        '{16'sd1999,   16'sd0,      1'b0, NO_REPORT}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    gmt_in_if  frame_ch();
    gmt_out_if report_ch();

    geared_multiturn_encoder_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (frame_ch),
        .o_out   (report_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Tracker state mirror
    logic [RATIO_W-1:0]     gear_ratio     = RATIO_W'(1);
    logic signed [15:0]     last_speed     = '0;
    logic                   near_top       = 1'b0;
    logic                   crossed_top    = 1'b0;
    logic                   near_bottom    = 1'b0;
    logic                   crossed_bottom = 1'b0;
    logic signed [15:0]     minor_turns    = '0;
    logic signed [31:0]     record_value   = '0;
    logic signed [31:0]     within_value   = '0;
    logic signed [23:0]     major_turns    = '0;
    logic signed [31:0]     held_angle     = '0;
    logic signed [47:0]     held_total     = '0;

    shaft_report_t          awaited_reports[$];
    int                     mismatch_count = 0;
    int                     cycle_count    = 0;
    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;
    int                     hold_request   = 0;
    int                     hold_left      = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advance the mirror by one frame and return the report it should give
    function automatic shaft_report_t track_frame(input logic signed [15:0] pos,
                                                  input logic signed [15:0] spd);
        shaft_report_t r;
        longint        ratio;
        longint        minor;
        longint        rec;
        longint        within_cnt;
        ratio   = (gear_ratio == '0) ? 64'sd1 : longint'(gear_ratio);
        r.fault = (pos <= 0) || (pos > ENC_COUNTS);
        r.accel = ACC_W'(longint'(spd) - longint'(last_speed));
        last_speed = spd;

        // band flags
        if (pos < TOP_BAND && pos > BOTTOM_BAND) begin
            near_top       = 1'b0;
            crossed_top    = 1'b0;
            near_bottom    = 1'b0;
            crossed_bottom = 1'b0;
        end else if (pos > TOP_BAND) begin
            near_top = 1'b1;
        end else if (pos < BOTTOM_BAND) begin
            near_bottom = 1'b1;
        end
        if (near_top && pos < BOTTOM_BAND) begin
            crossed_top = 1'b1;
        end else if (near_bottom && pos > TOP_BAND) begin
            crossed_bottom = 1'b1;
        end

        // rotor wraps
        if (near_top && crossed_top) begin
            minor_turns  = minor_turns + 16'sd1;
            record_value = record_value + ENC_COUNTS;
            near_top     = 1'b0;
            crossed_top  = 1'b0;
        end else if (near_bottom && crossed_bottom) begin
            minor_turns    = minor_turns - 16'sd1;
            record_value   = record_value - ENC_COUNTS;
            near_bottom    = 1'b0;
            crossed_bottom = 1'b0;
        end

        minor = longint'(minor_turns);
        rec   = longint'(record_value);
        if (minor > 0) begin
            within_cnt = minor * ENC_COUNTS + pos;
        end else if (minor < 0 || rec > ENC_COUNTS) begin
            within_cnt = ENC_COUNTS * ratio + (minor - 1) * ENC_COUNTS + pos;
        end else begin
            within_cnt = pos;
        end
        within_value = CNT_W'(within_cnt);

        // shaft turn steps hold the previous angles
        if (rec > ENC_COUNTS * ratio) begin
            record_value = CNT_W'(longint'(pos));
            major_turns  = major_turns + 24'sd1;
            minor_turns  = '0;
        end else if (rec < 0) begin
            record_value = CNT_W'(ENC_COUNTS * (ratio - 1) + pos);
            major_turns  = major_turns - 24'sd1;
            minor_turns  = '0;
        end else begin
            held_angle = ANG_W'((longint'(within_value) * ANGLE_SCALE) / ratio);
            held_total = TOT_W'(longint'(major_turns) * TURN_Q16 + longint'(held_angle));
        end

        r.shaft_count     = within_value;
        r.shaft_turns     = major_turns;
        r.angle_deg       = held_angle;
        r.total_angle_deg = held_total;
        return r;
    endfunction

    // Offer one frame, starting and ending at a falling edge
    task automatic send_frame(input logic signed [15:0] pos, input logic signed [15:0] spd,
                              input logic typed, input shaft_report_t want);
        shaft_report_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            frame_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.raw_position <= pos;
        frame_ch.speed_sample <= spd;
        @(posedge i_clk);
        while (!frame_ch.ready) @(posedge i_clk);
        predicted = track_frame(pos, spd);
        awaited_reports.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Stop offering, let every report come back, then let the block settle
    task automatic drain_reports();
        frame_ch.valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gear_ratio(input logic [RATIO_W-1:0] ratio);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GEAR_RATIO_ADDR;
        pwdata  <= APB_DATA_W'(ratio);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        gear_ratio = ratio;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 73;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 73;
            end
            default: begin
                send_idle_pct  = 26;
                recv_stall_pct = 26;
            end
        endcase
    endtask

    // Receiver ready, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            report_ch.ready <= 1'b0;
        end else begin
            report_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Report checker
    always @(posedge i_clk) begin
        shaft_report_t want;
        shaft_report_t got;
        got = '{report_ch.fault, report_ch.accel, report_ch.shaft_count,
                report_ch.shaft_turns, report_ch.angle_deg, report_ch.total_angle_deg};
        if (i_rst_n && report_ch.valid && report_ch.ready) begin
            if (awaited_reports.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected report word: fault=%0d accel=%0d count=%0d turns=%0d",
                             got.fault, got.accel, got.shaft_count, got.shaft_turns);
            end else begin
                want = awaited_reports.pop_front();
                if (got.fault !== want.fault || got.accel !== want.accel
                        || got.shaft_count !== want.shaft_count
                        || got.shaft_turns !== want.shaft_turns
                        || got.angle_deg !== want.angle_deg
                        || got.total_angle_deg !== want.total_angle_deg) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("report mismatch: exp fault=%0d accel=%0d count=%0d turns=%0d",
                                 want.fault, want.accel, want.shaft_count, want.shaft_turns);
                        $display("                 got fault=%0d accel=%0d count=%0d turns=%0d",
                                 got.fault, got.accel, got.shaft_count, got.shaft_turns);
                        $display("                 exp angle=%0d total=%0d got angle=%0d total=%0d",
                                 want.angle_deg, want.total_angle_deg,
                                 got.angle_deg, got.total_angle_deg);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [RATIO_W-1:0] set_ratios [8];
        int                 rotor;
        int                 dir;
        int                 delta;
        int                 spd_val;
        logic signed [15:0] pos;
        logic signed [15:0] spd;

        frame_ch.valid        = 1'b0;
        frame_ch.raw_position = '0;
        frame_ch.speed_sample = '0;
        report_ch.ready       = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed frames at the reset ratio
        set_idling(IDLE_NONE);
        for (int i = 0; i < DIR_ROWS; i++)
            send_frame(FRAME_TABLE[i].pos, FRAME_TABLE[i].spd,
                       FRAME_TABLE[i].typed, FRAME_TABLE[i].want);
        drain_reports();

        // ratio sets: zero acts as one, then the extremes and a few in between
        set_ratios = '{8'd0, 8'd255, 8'd2, 8'd1, 8'd7, 8'd3, 8'd128,
                       RATIO_W'($urandom_range(4, 254))};
        rotor = 4096;
        dir   = 1;
        for (int s = 0; s < 8; s++) begin
            write_gear_ratio(set_ratios[s]);
            set_idling(IDLE_NONE);
            // long receiver hold-off while frames keep coming
            if (s == 2)
                hold_request = LONG_HOLD;
            for (int n = 0; n < FRAMES_PER_SET; n++) begin
                if (n == CALM_FRAMES)
                    set_idling(idle_mode_t'(s % 4));
                if ($urandom_range(99) < 10) begin
                    // noise: any word at all
                    pos = 16'($urandom);
                    spd = 16'($urandom);
                end else begin
                    // rotor motion with occasional reversals and jumps
                    if ($urandom_range(99) < 5)
                        dir = -dir;
                    delta = dir * $urandom_range(0, 1500);
                    if ($urandom_range(99) < 3)
                        rotor = $urandom_range(1, ENC_PERIOD);
                    else
                        rotor = ((rotor - 1 + delta) % ENC_PERIOD + ENC_PERIOD)
                                % ENC_PERIOD + 1;
                    spd_val = delta * 20 + $urandom_range(0, 200) - 100;
                    pos = 16'(rotor);
                    spd = 16'(spd_val);
                end
                send_frame(pos, spd, 1'b0, NO_REPORT);
            end
            drain_reports();
        end

        if (mismatch_count == 0 && awaited_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
